>>> hdl/cpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartesian / polar converter package
// Shared types, fixed-point constants and elaboration-time table functions.
// ----------------------------------------------------------------------------
package cpc_pkg;

    // Coordinate datapath: Q16.16 plus eight guard fraction bits, with headroom
    // for the CORDIC gain and the sqrt(2) growth of the vector length.
    localparam int COORD_W    = 44;
    localparam int GUARD_BITS = 8;
    localparam int PROD_W     = 65;
    localparam int PRESCALE_SH = 30 - GUARD_BITS;

    // Inverse CORDIC gain in Q1.30.
    localparam logic signed [31:0] GAIN_INV_Q30 = 32'sd652032874;

    localparam longint PI_Q60         = 64'sh3243F6A8885A308D;
    localparam longint HALF_PI_Q60    = 64'sh1921FB54442D1846;
    localparam longint QUARTER_PI_Q60 = 64'sh0C90FDAA22168C23;

    localparam longint PI_Q29     = 64'sd1686629713;
    localparam longint RADIUS_MAX = 64'sd3037000499;
    localparam longint S32_MAX    = 64'sd2147483647;
    localparam longint S32_MIN    = -64'sd2147483648;

    typedef struct packed {
        logic valid;
        logic op;
        logic origin;
    } cpc_ctrl_t;

    // Round a positive Q60 value half up to the given number of fraction bits.
    function automatic longint q60_round(longint v, int frac);
        int sh;
        sh = 60 - frac;
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    // Floor of 2^sh over a positive divisor, by restoring long division.
    function automatic longint pow2_div(int sh, longint d);
        longint rem;
        longint quo;
        rem = 64'sd0;
        quo = 64'sd0;
        for (int j = 62; j >= 0; j--) begin
            rem = rem <<< 1;
            if (j == sh) begin
                rem = rem + 64'sd1;
            end
            quo = quo <<< 1;
            if (rem >= d) begin
                rem = rem - d;
                quo = quo + 64'sd1;
            end
        end
        return quo;
    endfunction

    // atan(2^-idx) in Q60 from the alternating Taylor series; idx 0 returns pi/4 directly.
    function automatic longint atan_q60(int idx);
        longint acc;
        longint term;
        int     e;
        acc = 64'sd0;
        if (idx == 0) begin
            acc = QUARTER_PI_Q60;
        end else begin
            for (int k = 0; k < 31; k++) begin
                e = idx * (2 * k + 1);
                if (e <= 60) begin
                    term = pow2_div(60 - e, longint'(2 * k + 1));
                    acc  = k[0] ? (acc - term) : (acc + term);
                end
            end
        end
        return acc;
    endfunction

endpackage

>>> hdl/cpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartesian / polar converter front end
// Angle conditioning, quadrant folding, 1/K prescale and the start vector
// of the CORDIC, in five register stages.
// ----------------------------------------------------------------------------
module cpc_front
    import cpc_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic                          in_op,
    input  logic signed [31:0]            in_a,
    input  logic signed [31:0]            in_b,
    output cpc_ctrl_t                     out_ctrl,
    output logic signed [COORD_W-1:0]     out_x,
    output logic signed [COORD_W-1:0]     out_y,
    output logic signed [DATA_WIDTH:0]    out_z
);

    localparam int ZW       = DATA_WIDTH + 1;
    localparam int ANG_FRAC = DATA_WIDTH - 3;
    localparam int ANG_DN   = (ANG_FRAC >= 29) ? (ANG_FRAC - 29) : 0;
    localparam int ANG_UP   = (ANG_FRAC < 29) ? (29 - ANG_FRAC) : 0;
    localparam int IW       = ((DATA_WIDTH > 32) ? DATA_WIDTH : 32) + 1;
    localparam int IN_HALF_SH = (ANG_UP > 0) ? (ANG_UP - 1) : 0;

    localparam logic signed [IW-1:0] IN_HALF =
        (ANG_UP > 0) ? (IW'(1) <<< IN_HALF_SH) : IW'(0);
    localparam logic signed [ZW-1:0] PI_F      = ZW'(q60_round(PI_Q60, ANG_FRAC));
    localparam logic signed [ZW-1:0] NEG_PI_F  = -PI_F;
    localparam logic signed [ZW-1:0] TWO_PI_F  = ZW'(2 * q60_round(PI_Q60, ANG_FRAC));
    localparam logic signed [ZW-1:0] HALF_PI_F = ZW'(q60_round(HALF_PI_Q60, ANG_FRAC));
    localparam logic signed [ZW-1:0] NEG_HALF_PI_F = -HALF_PI_F;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (PRESCALE_SH - 1);

    // Stage 1: angle into accumulator format and wrapped once by 2*pi.
    cpc_ctrl_t                c1_reg, c1_next;
    logic                     bneg1_reg;
    logic signed [32:0]       a1_reg, a1_next;
    logic signed [32:0]       b1_reg, b1_next;
    logic signed [ZW-1:0]     z1_reg, z1_next;
    logic signed [IW-1:0]     b_ext;
    logic signed [IW-1:0]     ang_in;
    logic signed [ZW-1:0]     z_in;

    always_comb begin
        b_ext  = IW'(in_b);
        ang_in = ((b_ext <<< ANG_DN) + IN_HALF) >>> ANG_UP;
        z_in   = ZW'(ang_in);
        if (z_in > PI_F) begin
            z1_next = z_in - TWO_PI_F;
        end else if (z_in < NEG_PI_F) begin
            z1_next = z_in + TWO_PI_F;
        end else begin
            z1_next = z_in;
        end
        a1_next        = 33'(in_a);
        b1_next        = 33'(in_b);
        c1_next.valid  = in_valid;
        c1_next.op     = in_op;
        c1_next.origin = !in_op && (in_a == 32'sd0) && (in_b == 32'sd0);
    end

    // Stage 2: a polar angle beyond +-pi/2 turns by pi and negates the radius.
    cpc_ctrl_t                c2_reg;
    logic                     bneg2_reg;
    logic signed [32:0]       a2_reg, a2_next;
    logic signed [32:0]       b2_reg;
    logic signed [ZW-1:0]     z2_reg, z2_next;

    always_comb begin
        a2_next = a1_reg;
        z2_next = z1_reg;
        if (c1_reg.op) begin
            if (z1_reg > HALF_PI_F) begin
                a2_next = -a1_reg;
                z2_next = z1_reg - PI_F;
            end else if (z1_reg < NEG_HALF_PI_F) begin
                a2_next = -a1_reg;
                z2_next = z1_reg + PI_F;
            end
        end else begin
            z2_next = '0;
        end
    end

    // Stage 3: multiply by the inverse gain.
    cpc_ctrl_t                c3_reg;
    logic                     bneg3_reg;
    logic signed [PROD_W-1:0] px3_reg, px3_next;
    logic signed [PROD_W-1:0] py3_reg, py3_next;
    logic signed [ZW-1:0]     z3_reg;

    always_comb begin
        px3_next = a2_reg * GAIN_INV_Q30;
        py3_next = c2_reg.op ? PROD_W'(0) : (b2_reg * GAIN_INV_Q30);
    end

    // Stage 4: round the products to the guarded coordinate format.
    cpc_ctrl_t                c4_reg;
    logic                     bneg4_reg;
    logic signed [COORD_W-1:0] x4_reg, x4_next;
    logic signed [COORD_W-1:0] y4_reg, y4_next;
    logic signed [ZW-1:0]     z4_reg;
    logic signed [PROD_W-1:0] px_rnd;
    logic signed [PROD_W-1:0] py_rnd;

    always_comb begin
        px_rnd  = (px3_reg + ROUND_HALF) >>> PRESCALE_SH;
        py_rnd  = (py3_reg + ROUND_HALF) >>> PRESCALE_SH;
        x4_next = px_rnd[COORD_W-1:0];
        y4_next = py_rnd[COORD_W-1:0];
    end

    // Stage 5: a vector in the left half plane starts turned by pi.
    cpc_ctrl_t                c5_reg;
    logic signed [COORD_W-1:0] x5_reg, x5_next;
    logic signed [COORD_W-1:0] y5_reg, y5_next;
    logic signed [ZW-1:0]     z5_reg, z5_next;

    always_comb begin
        x5_next = x4_reg;
        y5_next = y4_reg;
        z5_next = z4_reg;
        if (!c4_reg.op && x4_reg[COORD_W-1]) begin
            x5_next = -x4_reg;
            y5_next = -y4_reg;
            z5_next = bneg4_reg ? NEG_PI_F : PI_F;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
        end else if (en) begin
            c1_reg <= c1_next;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
            c4_reg <= c3_reg;
            c5_reg <= c4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bneg1_reg <= in_b[31];
            a1_reg    <= a1_next;
            b1_reg    <= b1_next;
            z1_reg    <= z1_next;
            bneg2_reg <= bneg1_reg;
            a2_reg    <= a2_next;
            b2_reg    <= b1_reg;
            z2_reg    <= z2_next;
            bneg3_reg <= bneg2_reg;
            px3_reg   <= px3_next;
            py3_reg   <= py3_next;
            z3_reg    <= z2_reg;
            bneg4_reg <= bneg3_reg;
            x4_reg    <= x4_next;
            y4_reg    <= y4_next;
            z4_reg    <= z3_reg;
            x5_reg    <= x5_next;
            y5_reg    <= y5_next;
            z5_reg    <= z5_next;
        end
    end

    assign out_ctrl = c5_reg;
    assign out_x    = x5_reg;
    assign out_y    = y5_reg;
    assign out_z    = z5_reg;

endmodule

>>> hdl/cpc_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartesian / polar converter CORDIC stage
// One registered micro-rotation, vectoring or rotation mode by the item's op.
// ----------------------------------------------------------------------------
module cpc_stage
    import cpc_pkg::*;
#(
    parameter int                     ZW       = 33,
    parameter int                     SHIFT    = 0,
    parameter logic signed [ZW-1:0]   ATAN_VAL = '0
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  cpc_ctrl_t                 in_ctrl,
    input  logic signed [COORD_W-1:0] in_x,
    input  logic signed [COORD_W-1:0] in_y,
    input  logic signed [ZW-1:0]      in_z,
    output cpc_ctrl_t                 out_ctrl,
    output logic signed [COORD_W-1:0] out_x,
    output logic signed [COORD_W-1:0] out_y,
    output logic signed [ZW-1:0]      out_z
);

    cpc_ctrl_t                 ctrl_reg;
    logic signed [COORD_W-1:0] x_reg, x_next;
    logic signed [COORD_W-1:0] y_reg, y_next;
    logic signed [ZW-1:0]      z_reg, z_next;
    logic                      ccw;
    logic signed [COORD_W-1:0] x_sh;
    logic signed [COORD_W-1:0] y_sh;

    // Vectoring drives y toward zero; rotation drives z toward zero.
    always_comb begin
        ccw  = in_ctrl.op ? !in_z[ZW-1] : in_y[COORD_W-1];
        x_sh = in_x >>> SHIFT;
        y_sh = in_y >>> SHIFT;
        if (ccw) begin
            x_next = in_x - y_sh;
            y_next = in_y + x_sh;
            z_next = in_z - ATAN_VAL;
        end else begin
            x_next = in_x + y_sh;
            y_next = in_y - x_sh;
            z_next = in_z + ATAN_VAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= in_ctrl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign out_ctrl = ctrl_reg;
    assign out_x    = x_reg;
    assign out_y    = y_reg;
    assign out_z    = z_reg;

endmodule

>>> hdl/cpc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartesian / polar converter back end
// Drops the guard bits, converts the angle to Q3.29 and saturates, in two
// register stages; the second is the output register.
// ----------------------------------------------------------------------------
module cpc_back
    import cpc_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  cpc_ctrl_t                 in_ctrl,
    input  logic signed [COORD_W-1:0] in_x,
    input  logic signed [COORD_W-1:0] in_y,
    input  logic signed [DATA_WIDTH:0] in_z,
    output logic                      out_valid,
    output logic signed [32:0]        out_first,
    output logic signed [31:0]        out_second
);

    localparam int ZW       = DATA_WIDTH + 1;
    localparam int ANG_FRAC = DATA_WIDTH - 3;
    localparam int ANG_DN   = (ANG_FRAC >= 29) ? (ANG_FRAC - 29) : 0;
    localparam int ANG_UP   = (ANG_FRAC < 29) ? (29 - ANG_FRAC) : 0;
    localparam int AO_W     = ZW + ANG_UP + 1;
    localparam int ANG_HALF_SH = (ANG_DN > 0) ? (ANG_DN - 1) : 0;

    localparam logic signed [AO_W-1:0] ANG_HALF =
        (ANG_DN > 0) ? (AO_W'(1) <<< ANG_HALF_SH) : AO_W'(0);
    localparam logic signed [AO_W-1:0] ANG_MAX = AO_W'(PI_Q29);
    localparam logic signed [AO_W-1:0] ANG_MIN = -ANG_MAX;
    localparam logic signed [COORD_W-1:0] CRD_HALF = COORD_W'(1) <<< (GUARD_BITS - 1);
    localparam logic signed [COORD_W-1:0] R_MAX = COORD_W'(RADIUS_MAX);
    localparam logic signed [COORD_W-1:0] C_MAX = COORD_W'(S32_MAX);
    localparam logic signed [COORD_W-1:0] C_MIN = COORD_W'(S32_MIN);

    // Stage 1: rounding.
    cpc_ctrl_t                 c1_reg;
    logic signed [COORD_W-1:0] xr_reg, xr_next;
    logic signed [COORD_W-1:0] yr_reg, yr_next;
    logic signed [AO_W-1:0]    ang_reg, ang_next;
    logic signed [AO_W-1:0]    z_ext;

    always_comb begin
        xr_next  = (in_x + CRD_HALF) >>> GUARD_BITS;
        yr_next  = (in_y + CRD_HALF) >>> GUARD_BITS;
        z_ext    = AO_W'(in_z);
        ang_next = ((z_ext + ANG_HALF) >>> ANG_DN) <<< ANG_UP;
    end

    // Stage 2: clamping and selection by op.
    logic                      valid_reg;
    logic signed [32:0]        first_reg, first_next;
    logic signed [31:0]        second_reg, second_next;
    logic signed [COORD_W-1:0] xs;
    logic signed [COORD_W-1:0] ys;
    logic signed [COORD_W-1:0] rad;
    logic signed [AO_W-1:0]    ang_c;

    always_comb begin
        xs = xr_reg;
        if (xr_reg > C_MAX) begin
            xs = C_MAX;
        end else if (xr_reg < C_MIN) begin
            xs = C_MIN;
        end
        ys = yr_reg;
        if (yr_reg > C_MAX) begin
            ys = C_MAX;
        end else if (yr_reg < C_MIN) begin
            ys = C_MIN;
        end
        rad = xr_reg;
        if (xr_reg[COORD_W-1]) begin
            rad = '0;
        end else if (xr_reg > R_MAX) begin
            rad = R_MAX;
        end
        ang_c = ang_reg;
        if (ang_reg > ANG_MAX) begin
            ang_c = ANG_MAX;
        end else if (ang_reg < ANG_MIN) begin
            ang_c = ANG_MIN;
        end

        if (c1_reg.op) begin
            first_next  = xs[32:0];
            second_next = ys[31:0];
        end else if (c1_reg.origin) begin
            first_next  = '0;
            second_next = '0;
        end else begin
            first_next  = rad[32:0];
            second_next = ang_c[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg    <= '0;
            valid_reg <= 1'b0;
        end else if (en) begin
            c1_reg    <= in_ctrl;
            valid_reg <= c1_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xr_reg     <= xr_next;
            yr_reg     <= yr_next;
            ang_reg    <= ang_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_first  = first_reg;
    assign out_second = second_reg;

endmodule

>>> hdl/cartesian_polar_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartesian / polar converter
// Fully pipelined CORDIC converting points between Cartesian and polar form.
// ----------------------------------------------------------------------------
// The block accepts one point per clock cycle unless a result is held back at
// the output by m_tready low. Each point passes through five front-end stages,
// one registered stage per CORDIC micro-rotation (ITERATIONS of them, 28 by
// default) and two back-end stages, the last of which is the output register.
// With s_tuser low, s_tdata carries x and y in Q16.16 and the result
// is the radius in Q16.16 and atan2(y, x) in Q3.29 radians; with s_tuser high,
// it carries a radius in Q16.16 and an angle in Q3.29 and the result is x and
// y in Q16.16, saturated to 32 bits. The whole pipeline holds while a result
// waits at the output, so s_tready follows m_tready whenever m_tvalid is high.
// DATA_WIDTH sets the width of the angle accumulator.
module cartesian_polar_converter
    import cpc_pkg::*;
#(
    parameter int ITERATIONS = 28,
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] first_in, [63:32] second_in
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [32:0] first_out, [64:33] second_out, rest zero
);

    localparam int ZW       = DATA_WIDTH + 1;
    localparam int ANG_FRAC = DATA_WIDTH - 3;

    logic en;

    cpc_ctrl_t                 ctrl_q [ITERATIONS+1];
    logic signed [COORD_W-1:0] x_q    [ITERATIONS+1];
    logic signed [COORD_W-1:0] y_q    [ITERATIONS+1];
    logic signed [ZW-1:0]      z_q    [ITERATIONS+1];

    logic                      res_valid;
    logic signed [32:0]        res_first;
    logic signed [31:0]        res_second;

    // The pipeline moves when the output register is empty or being read.
    assign en       = !res_valid || m_tready;
    assign s_tready = en;

    cpc_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_a     (s_tdata[31:0]),
        .in_b     (s_tdata[63:32]),
        .out_ctrl (ctrl_q[0]),
        .out_x    (x_q[0]),
        .out_y    (y_q[0]),
        .out_z    (z_q[0])
    );

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_iter
        cpc_stage #(
            .ZW       (ZW),
            .SHIFT    (g),
            .ATAN_VAL (ZW'(q60_round(atan_q60(g), ANG_FRAC)))
        ) u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_ctrl  (ctrl_q[g]),
            .in_x     (x_q[g]),
            .in_y     (y_q[g]),
            .in_z     (z_q[g]),
            .out_ctrl (ctrl_q[g+1]),
            .out_x    (x_q[g+1]),
            .out_y    (y_q[g+1]),
            .out_z    (z_q[g+1])
        );
    end

    cpc_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_ctrl    (ctrl_q[ITERATIONS]),
        .in_x       (x_q[ITERATIONS]),
        .in_y       (y_q[ITERATIONS]),
        .in_z       (z_q[ITERATIONS]),
        .out_valid  (res_valid),
        .out_first  (res_first),
        .out_second (res_second)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = {7'd0, res_second, res_first};

endmodule

>>> tb/cartesian_polar_converter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartesian / polar converter testbench
// Streams points in both conversion directions through the CORDIC pipeline
// with random idle bursts on both sides. A bit-exact software CORDIC predicts
// every result, and a scoreboard checks results in order.
// ----------------------------------------------------------------------------
module cartesian_polar_converter_tb;

    localparam int ITERATIONS  = 28;
    localparam int DATA_WIDTH  = 32;
    localparam int LATENCY     = ITERATIONS + 7;
    localparam int RANDOM_ITEMS = 1200;
    localparam int TAIL_ITEMS  = 150;
    localparam int LONG_HOLD   = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic OP_TO_POLAR     = 1'b0;
    localparam logic OP_TO_CARTESIAN = 1'b1;

    localparam logic [31:0] S32_MAX_BITS = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN_BITS = 32'h8000_0000;
    localparam longint ANGLE_PI      = 64'sd1686629713;
    localparam longint ANGLE_HALF_PI = 64'sd843314857;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [31:0] first_in, [63:32] second_in
    logic        s_tuser;   // [0] op
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // [32:0] first_out, [64:33] second_out, rest zero

    bit tail_phase;
    bit long_hold_req;

    typedef struct {
        logic [32:0] first;
        logic [31:0] second;
    } point_t;

    class point_scoreboard;
        localparam int ANG_FRAC = DATA_WIDTH - 3;
        localparam int GUARD    = 8;
        localparam longint GAIN_INV  = 64'sd652032874;
        localparam longint PI_Q60    = 64'sh3243F6A8885A308D;
        localparam longint HPI_Q60   = 64'sh1921FB54442D1846;
        localparam longint QPI_Q60   = 64'sh0C90FDAA22168C23;
        localparam longint RADIUS_LIMIT = 64'sd3037000499;

        longint atan_lut[32];
        longint acc_pi;
        longint acc_half_pi;
        point_t pending_points[$];
        int     error_count;

        function new();
            longint sum;
            longint term;
            int     e;
            atan_lut[0] = round_shift(QPI_Q60, 60 - ANG_FRAC);
            for (int i = 1; i < 32; i++) begin
                sum = 0;
                for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
                    e = i * (2 * k + 1);
                    term = (64'sd1 <<< (60 - e)) / longint'(2 * k + 1);
                    sum = k[0] ? sum - term : sum + term;
                end
                atan_lut[i] = round_shift(sum, 60 - ANG_FRAC);
            end
            acc_pi      = round_shift(PI_Q60, 60 - ANG_FRAC);
            acc_half_pi = round_shift(HPI_Q60, 60 - ANG_FRAC);
            error_count = 0;
        endfunction

        // Arithmetic shifts on longint floor toward minus infinity.
        function longint round_shift(longint v, int s);
            if (s == 0)
                return v;
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function longint saturate32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function point_t convert_point(logic op, logic signed [31:0] first_in,
                                       logic signed [31:0] second_in);
            point_t res;
            longint a;
            longint b;
            longint x;
            longint y;
            longint z;
            longint nx;
            longint r;
            longint ang;
            a = first_in;
            b = second_in;
            if (op == OP_TO_POLAR) begin
                r = 0;
                ang = 0;
                // The origin bypasses the iterations and gives zero for both.
                if (a != 0 || b != 0) begin
                    x = round_shift(a * GAIN_INV, 30 - GUARD);
                    y = round_shift(b * GAIN_INV, 30 - GUARD);
                    z = 0;
                    if (x < 0) begin
                        x = -x;
                        y = -y;
                        z = (b >= 0) ? acc_pi : -acc_pi;
                    end
                    for (int i = 0; i < ITERATIONS && i < 32; i++) begin
                        if (y >= 0) begin
                            nx = x + (y >>> i);
                            y  = y - (x >>> i);
                            z  = z + atan_lut[i];
                        end else begin
                            nx = x - (y >>> i);
                            y  = y + (x >>> i);
                            z  = z - atan_lut[i];
                        end
                        x = nx;
                    end
                    r = round_shift(x, GUARD);
                    if (r < 0)
                        r = 0;
                    if (r > RADIUS_LIMIT)
                        r = RADIUS_LIMIT;
                    if (ANG_FRAC >= 29)
                        ang = round_shift(z, ANG_FRAC - 29);
                    else
                        ang = z <<< (29 - ANG_FRAC);
                    if (ang > ANGLE_PI)
                        ang = ANGLE_PI;
                    if (ang < -ANGLE_PI)
                        ang = -ANGLE_PI;
                end
                res.first  = r[32:0];
                res.second = ang[31:0];
            end else begin
                if (ANG_FRAC >= 29)
                    z = b <<< (ANG_FRAC - 29);
                else
                    z = round_shift(b, 29 - ANG_FRAC);
                if (z > acc_pi)
                    z = z - 2 * acc_pi;
                if (z < -acc_pi)
                    z = z + 2 * acc_pi;
                // Fold into the right half plane by flipping the radius.
                if (z > acc_half_pi) begin
                    a = -a;
                    z = z - acc_pi;
                end else if (z < -acc_half_pi) begin
                    a = -a;
                    z = z + acc_pi;
                end
                x = round_shift(a * GAIN_INV, 30 - GUARD);
                y = 0;
                for (int i = 0; i < ITERATIONS && i < 32; i++) begin
                    if (z >= 0) begin
                        nx = x - (y >>> i);
                        y  = y + (x >>> i);
                        z  = z - atan_lut[i];
                    end else begin
                        nx = x + (y >>> i);
                        y  = y - (x >>> i);
                        z  = z + atan_lut[i];
                    end
                    x = nx;
                end
                r   = saturate32(round_shift(x, GUARD));
                ang = saturate32(round_shift(y, GUARD));
                res.first  = r[32:0];
                res.second = ang[31:0];
            end
            return res;
        endfunction

        function void note_point(logic op, logic [31:0] first_in, logic [31:0] second_in);
            pending_points.push_back(convert_point(op, first_in, second_in));
        endfunction

        function void check_result(logic [71:0] data);
            point_t exp_pt;
            if (pending_points.size() == 0) begin
                $display("%0t: result transfer with none expected, actual %h", $time, data);
                error_count++;
                return;
            end
            exp_pt = pending_points.pop_front();
            if (data[32:0] !== exp_pt.first) begin
                $display("%0t: first_out mismatch, expected %h, actual %h",
                         $time, exp_pt.first, data[32:0]);
                error_count++;
            end
            if (data[64:33] !== exp_pt.second) begin
                $display("%0t: second_out mismatch, expected %h, actual %h",
                         $time, exp_pt.second, data[64:33]);
                error_count++;
            end
            if (data[71:65] !== 7'd0) begin
                $display("%0t: padding mismatch, expected %h, actual %h",
                         $time, 7'd0, data[71:65]);
                error_count++;
            end
        endfunction

        function int pending_count();
            return pending_points.size();
        endfunction
    endclass

    point_scoreboard scoreboard = new();

    cartesian_polar_converter #(
        .ITERATIONS (ITERATIONS),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_TO_POLAR;
        m_tready <= 1'b0;
    end

    task automatic send_point(input logic op, input logic [31:0] first_in,
                              input logic [31:0] second_in);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {second_in, first_in};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic idle_sender(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (scoreboard.pending_count() != 0);
    endtask

    function automatic logic [31:0] random_coord();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5: v = int'($urandom_range(0, 262143)) - 131072;
            6: begin
                case ($urandom_range(0, 4))
                    0: v = S32_MAX_BITS;
                    1: v = S32_MIN_BITS;
                    2: v = 0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
            default: begin
                v = $urandom;
                v = v >>> $urandom_range(0, 24);
            end
        endcase
        return v;
    endfunction

    function automatic logic [31:0] random_angle();
        longint t;
        case ($urandom_range(0, 9))
            0, 1, 2: t = longint'($urandom);
            3: begin
                // Near the wrap and fold boundaries.
                t = ($urandom_range(0, 1) ? ANGLE_PI : ANGLE_HALF_PI)
                    + longint'($urandom_range(0, 8)) - 4;
                if ($urandom_range(0, 1))
                    t = -t;
            end
            default: t = longint'($urandom_range(0, 32'd3373259426)) - ANGLE_PI;
        endcase
        return t[31:0];
    endfunction

    initial begin
        logic op;
        bit   gappy;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed points: origin, axis directions, extremes and wraps.
        send_point(OP_TO_POLAR, 32'd0, 32'd0);
        send_point(OP_TO_POLAR, S32_MAX_BITS, S32_MAX_BITS);
        send_point(OP_TO_POLAR, S32_MIN_BITS, S32_MIN_BITS);
        send_point(OP_TO_POLAR, S32_MIN_BITS, 32'd0);
        send_point(OP_TO_POLAR, -32'sd1, 32'd0);
        send_point(OP_TO_POLAR, -32'sd65536, -32'sd1);
        send_point(OP_TO_POLAR, 32'd0, S32_MIN_BITS);
        send_point(OP_TO_POLAR, 32'd0, S32_MAX_BITS);
        send_point(OP_TO_POLAR, S32_MAX_BITS, 32'd0);
        send_point(OP_TO_POLAR, 32'd1, 32'd1);
        send_point(OP_TO_POLAR, S32_MIN_BITS, S32_MAX_BITS);
        idle_sender(3);
        send_point(OP_TO_CARTESIAN, 32'd65536, 32'd0);
        send_point(OP_TO_CARTESIAN, S32_MAX_BITS, ANGLE_PI[31:0]);
        send_point(OP_TO_CARTESIAN, S32_MAX_BITS, S32_MAX_BITS);
        send_point(OP_TO_CARTESIAN, S32_MAX_BITS, S32_MIN_BITS);
        send_point(OP_TO_CARTESIAN, S32_MIN_BITS, 32'd0);
        send_point(OP_TO_CARTESIAN, -32'sd65536, ANGLE_HALF_PI[31:0]);
        send_point(OP_TO_CARTESIAN, S32_MAX_BITS, ANGLE_HALF_PI[31:0]);
        send_point(OP_TO_CARTESIAN, S32_MAX_BITS, 32'd0);
        send_point(OP_TO_CARTESIAN, S32_MIN_BITS, -32'sd421657428);
        send_point(OP_TO_CARTESIAN, 32'd0, 32'd12345);
        send_point(OP_TO_CARTESIAN, S32_MIN_BITS, S32_MIN_BITS);

        gappy = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0)
                gappy = 1'($urandom_range(0, 1));
            if (n == 320) begin
                // Keep offering while the receiver holds off, so the pipe fills.
                gappy = 1'b0;
                long_hold_req = 1'b1;
            end
            if (n == 640)
                wait_for_drain();
            if (n == RANDOM_ITEMS - TAIL_ITEMS) begin
                tail_phase = 1'b1;
                gappy = 1'b0;
            end
            if (gappy && $urandom_range(0, 2) == 0)
                idle_sender($urandom_range(1, 15));
            op = 1'($urandom_range(0, 1));
            if (op == OP_TO_POLAR)
                send_point(op, random_coord(), random_coord());
            else
                send_point(op, random_coord(), random_angle());
        end

        wait_for_drain();
        repeat (LATENCY + 10) @(posedge aclk);
        if (scoreboard.error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        bit rx_gappy;
        rx_gappy = 1'b1;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 19) == 0)
                rx_gappy = ~rx_gappy;
            if (tail_phase) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_req = 1'b0;
            end else if (rx_gappy && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                scoreboard.note_point(s_tuser, s_tdata[31:0], s_tdata[63:32]);
            if (m_tvalid && m_tready)
                scoreboard.check_result(m_tdata);
        end
    end

    // Counts cycles without any transfer on either side.
    int stall_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog timeout", $time);
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
